// ===== rtl/line_rasterizer_clipped_unit_assert.svh =====
// ----------------------------------------------------------------------------
// line rasterizer assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_CLIPPED_UNIT_ASSERT_SVH
`define LINE_RASTERIZER_CLIPPED_UNIT_ASSERT_SVH

// same-cycle implication
`define LRC_ASSERT_IMPLY(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define LRC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg
// shared types and constants of the clipped line rasterizer
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 13;
  localparam int INDEX_BITS    = 24;
  localparam int WORD_BITS     = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_LINE_RED     = 3'd2,
    CFG_LINE_GREEN   = 3'd3,
    CFG_LINE_BLUE    = 3'd4
  } lrc_cfg_idx_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [CFG_DATA_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DATA_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [7:0] LINE_RED_RST   = 8'd255;
  localparam logic [7:0] LINE_GREEN_RST = 8'd140;
  localparam logic [7:0] LINE_BLUE_RST  = 8'd0;
  localparam logic [7:0] PIXEL_ALPHA    = 8'd255;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lrc_colour_t;

endpackage

// ===== rtl/lrc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lrc_cfg_regs
// frame size and line colour registers, frame size saturated on write
// ----------------------------------------------------------------------------
module lrc_cfg_regs #(
  parameter int DIM_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lrc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lrc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output logic [DIM_BITS:0]                frame_w,
  output logic [DIM_BITS:0]                frame_h,
  output lrc_pkg::lrc_colour_t             colour
);
  import lrc_pkg::*;

  localparam int DW = DIM_BITS + 1;
  localparam int XW = (CFG_DATA_BITS > DW) ? CFG_DATA_BITS : DW;

  logic [DW-1:0] frame_w_r;
  logic [DW-1:0] frame_h_r;
  lrc_colour_t   colour_r;

  // saturate to 2^DIM_BITS
  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DATA_BITS-1:0] d);
    logic [XW-1:0] d_ext;
    logic [XW-1:0] d_max;
    logic [XW-1:0] d_sat;
    d_ext = XW'(d);
    d_max = XW'(1) << DIM_BITS;
    d_sat = (d_ext > d_max) ? d_max : d_ext;
    return d_sat[DW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r      <= clamp_dim(FRAME_WIDTH_RST);
      frame_h_r      <= clamp_dim(FRAME_HEIGHT_RST);
      colour_r.red   <= LINE_RED_RST;
      colour_r.green <= LINE_GREEN_RST;
      colour_r.blue  <= LINE_BLUE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_w_r      <= clamp_dim(cfg_wdata);
        CFG_FRAME_HEIGHT: frame_h_r      <= clamp_dim(cfg_wdata);
        CFG_LINE_RED:     colour_r.red   <= cfg_wdata[7:0];
        CFG_LINE_GREEN:   colour_r.green <= cfg_wdata[7:0];
        CFG_LINE_BLUE:    colour_r.blue  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign frame_w = frame_w_r;
  assign frame_h = frame_h_r;
  assign colour  = colour_r;

endmodule

// ===== rtl/lrc_walk.sv =====
// ----------------------------------------------------------------------------
// lrc_walk
// bresenham error-term walk, one pixel step per transfer, pixel register
// ----------------------------------------------------------------------------
module lrc_walk #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         s1_valid,
  input  logic                         s1_ready,
  output logic signed [COORD_BITS-1:0] s1_x,
  output logic signed [COORD_BITS-1:0] s1_y,
  output logic                         s1_last,
  output logic                         line_active
);
  import lrc_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int DW2 = COORD_BITS + 2;
  localparam int EW  = COORD_BITS + 3;
  localparam int E2W = COORD_BITS + 4;
  localparam logic signed [C-1:0] ONE = C'(1);

  logic signed [C-1:0]   cx_r, cy_r, tx_r, ty_r;
  logic signed [DW2-1:0] adx_r, nady_r;
  logic                  xneg_r, yneg_r;
  logic signed [EW-1:0]  err_r;
  logic                  active_r;
  logic                  s1_valid_r, s1_valid_nxt;
  logic signed [C-1:0]   s1_x_r, s1_y_r;
  logic                  s1_last_r;

  logic                  accept, gen;
  logic signed [DW2-1:0] ld_dx, ld_dy, ld_adx, ld_nady;
  logic signed [EW-1:0]  ld_err;
  logic                  ld_end;
  logic signed [E2W-1:0] e2, nady_e, adx_e;
  logic                  move_x, move_y;
  logic signed [EW-1:0]  add_x, add_y, st_err;
  logic signed [C-1:0]   st_x, st_y;
  logic                  st_end;

  assign in_ready = !s1_valid_r || s1_ready;
  assign accept   = in_valid && in_ready;
  assign gen      = (in_op == OP_LOAD) || active_r;

  // load set-up
  always_comb begin
    ld_dx   = {{2{in_end_x[C-1]}}, in_end_x} - {{2{in_start_x[C-1]}}, in_start_x};
    ld_dy   = {{2{in_end_y[C-1]}}, in_end_y} - {{2{in_start_y[C-1]}}, in_start_y};
    ld_adx  = ld_dx[DW2-1] ? -ld_dx : ld_dx;
    ld_nady = ld_dy[DW2-1] ? ld_dy : -ld_dy;
    ld_err  = {ld_adx[DW2-1], ld_adx} + {ld_nady[DW2-1], ld_nady};
    ld_end  = (in_start_x == in_end_x) && (in_start_y == in_end_y);
  end

  // one step of the walk
  always_comb begin
    e2     = {err_r, 1'b0};
    nady_e = {{2{nady_r[DW2-1]}}, nady_r};
    adx_e  = {{2{adx_r[DW2-1]}}, adx_r};
    move_x = e2 >= nady_e;
    move_y = e2 <= adx_e;
    add_x  = move_x ? {nady_r[DW2-1], nady_r} : '0;
    add_y  = move_y ? {adx_r[DW2-1], adx_r} : '0;
    st_err = err_r + add_x + add_y;
    st_x   = move_x ? (xneg_r ? cx_r - ONE : cx_r + ONE) : cx_r;
    st_y   = move_y ? (yneg_r ? cy_r - ONE : cy_r + ONE) : cy_r;
    st_end = (st_x == tx_r) && (st_y == ty_r);
  end

  always_comb begin
    if (accept) begin
      s1_valid_nxt = gen;
    end else begin
      s1_valid_nxt = s1_valid_r && !s1_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r       <= '0;
      cy_r       <= '0;
      tx_r       <= '0;
      ty_r       <= '0;
      adx_r      <= '0;
      nady_r     <= '0;
      xneg_r     <= 1'b0;
      yneg_r     <= 1'b0;
      err_r      <= '0;
      active_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept && (in_op == OP_LOAD)) begin
        cx_r      <= in_start_x;
        cy_r      <= in_start_y;
        tx_r      <= in_end_x;
        ty_r      <= in_end_y;
        adx_r     <= ld_adx;
        nady_r    <= ld_nady;
        xneg_r    <= !(in_start_x < in_end_x);
        yneg_r    <= !(in_start_y < in_end_y);
        err_r     <= ld_err;
        active_r  <= !ld_end;
      end else if (accept && active_r) begin
        cx_r      <= st_x;
        cy_r      <= st_y;
        err_r     <= st_err;
        active_r  <= !st_end;
      end
    end
  end

  // pixel register, loaded with every generated pixel
  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_LOAD)) begin
      s1_x_r    <= in_start_x;
      s1_y_r    <= in_start_y;
      s1_last_r <= ld_end;
    end else if (accept && active_r) begin
      s1_x_r    <= st_x;
      s1_y_r    <= st_y;
      s1_last_r <= st_end;
    end
  end

  assign s1_valid    = s1_valid_r;
  assign s1_x        = s1_x_r;
  assign s1_y        = s1_y_r;
  assign s1_last     = s1_last_r;
  assign line_active = active_r;

endmodule

// ===== rtl/lrc_emit.sv =====
// ----------------------------------------------------------------------------
// lrc_emit
// frame clipping, linear index and write word into the result register
// ----------------------------------------------------------------------------
module lrc_emit #(
  parameter int COORD_BITS = 16,
  parameter int DIM_BITS   = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  output logic                          s1_ready,
  input  logic signed [COORD_BITS-1:0]  s1_x,
  input  logic signed [COORD_BITS-1:0]  s1_y,
  input  logic                          s1_last,
  input  logic [DIM_BITS:0]             frame_w,
  input  logic [DIM_BITS:0]             frame_h,
  input  lrc_pkg::lrc_colour_t          colour,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS-1:0]  out_pixel_x,
  output logic signed [COORD_BITS-1:0]  out_pixel_y,
  output logic                          out_in_frame,
  output logic [lrc_pkg::INDEX_BITS-1:0] out_pixel_index,
  output logic [lrc_pkg::WORD_BITS-1:0]  out_pixel_word,
  output logic                          out_last
);
  import lrc_pkg::*;

  localparam int DW    = DIM_BITS + 1;
  localparam int CMPW  = (COORD_BITS > DW) ? COORD_BITS : DW;
  localparam int PRODW = DIM_BITS + DW;
  localparam int SUMW0 = ((PRODW > CMPW) ? PRODW : CMPW) + 1;
  localparam int SUMW  = (SUMW0 > INDEX_BITS) ? SUMW0 : INDEX_BITS;

  logic                  out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic                  in_frame_r, last_r;
  logic [INDEX_BITS-1:0] index_r;
  logic [WORD_BITS-1:0]  word_r;

  logic                  take;
  logic [CMPW-1:0]       xu, yu;
  logic                  pix_in_frame;
  logic [PRODW-1:0]      prod;
  logic [SUMW-1:0]       sum;
  logic [INDEX_BITS-1:0] index;

  assign s1_ready = !out_valid_r || out_ready;
  assign take     = s1_valid && s1_ready;

  always_comb begin
    xu     = CMPW'($unsigned(s1_x));
    yu     = CMPW'($unsigned(s1_y));
    // negative coordinates fail on the sign bit alone
    pix_in_frame = !s1_x[COORD_BITS-1] && !s1_y[COORD_BITS-1] &&
                   (xu < CMPW'(frame_w)) && (yu < CMPW'(frame_h));
    prod   = yu[DIM_BITS-1:0] * frame_w;
    sum    = SUMW'(prod) + SUMW'(xu);
    index  = pix_in_frame ? sum[INDEX_BITS-1:0] : '0;
  end

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      px_r       <= s1_x;
      py_r       <= s1_y;
      in_frame_r <= pix_in_frame;
      index_r    <= index;
      word_r     <= {PIXEL_ALPHA, colour.red, colour.green, colour.blue};
      last_r     <= s1_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_in_frame    = in_frame_r;
  assign out_pixel_index = index_r;
  assign out_pixel_word  = word_r;
  assign out_last        = last_r;

endmodule

// ===== rtl/line_rasterizer_clipped_unit.sv =====
// ----------------------------------------------------------------------------
// line_rasterizer_clipped_unit: clipped all-octant bresenham line generator
// input transfer goes through the walk pixel register, then the clip/index result register
// throughput one item per cycle unless out_ready stalls the output, one error-term update per step
// sync reset: no line active, pipeline empty, 640x480 frame, colour ff/8c/00
// ----------------------------------------------------------------------------
`include "line_rasterizer_clipped_unit_assert.svh"

module line_rasterizer_clipped_unit #(
  parameter int COORD_BITS = 16,
  parameter int DIM_BITS   = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lrc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lrc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic signed [COORD_BITS-1:0]    in_start_x,
  input  logic signed [COORD_BITS-1:0]    in_start_y,
  input  logic signed [COORD_BITS-1:0]    in_end_x,
  input  logic signed [COORD_BITS-1:0]    in_end_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [COORD_BITS-1:0]    out_pixel_x,
  output logic signed [COORD_BITS-1:0]    out_pixel_y,
  output logic                            out_in_frame,
  output logic [lrc_pkg::INDEX_BITS-1:0]   out_pixel_index,
  output logic [lrc_pkg::WORD_BITS-1:0]    out_pixel_word,
  output logic                            out_last
);
  import lrc_pkg::*;

  logic [DIM_BITS:0]            frame_w, frame_h;
  lrc_colour_t                  colour;
  logic                         s1_valid, s1_ready, s1_last, line_active;
  logic signed [COORD_BITS-1:0] s1_x, s1_y;

  lrc_cfg_regs #(
    .DIM_BITS (DIM_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .frame_w   (frame_w),
    .frame_h   (frame_h),
    .colour    (colour)
  );

  lrc_walk #(
    .COORD_BITS (COORD_BITS)
  ) u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_x        (s1_x),
    .s1_y        (s1_y),
    .s1_last     (s1_last),
    .line_active (line_active)
  );

  lrc_emit #(
    .COORD_BITS (COORD_BITS),
    .DIM_BITS   (DIM_BITS)
  ) u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1_valid        (s1_valid),
    .s1_ready        (s1_ready),
    .s1_x            (s1_x),
    .s1_y            (s1_y),
    .s1_last         (s1_last),
    .frame_w         (frame_w),
    .frame_h         (frame_h),
    .colour          (colour),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_in_frame    (out_in_frame),
    .out_pixel_index (out_pixel_index),
    .out_pixel_word  (out_pixel_word),
    .out_last        (out_last)
  );

  `LRC_ASSERT_NEXT(a_load_gives_pixel, in_valid && in_ready && (in_op == OP_LOAD), s1_valid, "load transfer did not produce a pixel")
  `LRC_ASSERT_IMPLY(a_last_ends_line, s1_valid && s1_last, !line_active, "line still active behind its end pixel")
  `LRC_ASSERT_IMPLY(a_clipped_index_zero, out_valid && !out_in_frame, out_pixel_index == '0, "clipped pixel has a non-zero index")

endmodule
